>>> sv/assert_macros.svh
// Assertion helpers used by the allocator core; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bba_pkg.sv
package bba_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WORD_W     = $clog2(MAP_WORDS);
	localparam int FUNC_W     = 3;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = PADDR_W - 2;

	localparam logic [FUNC_W-1:0] FUNC_SET      = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_CHECK    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FIND_SET = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FIND_CLR = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = '0;

	localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = CNT_W'(1024);
	localparam logic [CNT_W-1:0] BLOCK_COUNT_MAX   = CNT_W'(MAX_BLOCKS);

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  block_index;
		logic              expect_set;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] index;
	} rsp_t;

	typedef struct packed {
		logic                 rd_en;
		logic [WORD_W-1:0]    rd_addr;
		logic                 wr_en;
		logic [WORD_W-1:0]    wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} map_req_t;

endpackage

>>> sv/bba_map.sv
module bba_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::map_req_t             map_req,
	output logic [bba_pkg::WORD_BITS-1:0] rd_data
);

	logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::MAP_WORDS];
	logic [bba_pkg::WORD_BITS-1:0] mem_rd_s1;
	logic [bba_pkg::MAP_WORDS-1:0] row_valid_q;
	logic                          rd_valid_s1;

	// A row that was never written since reset reads as all free.
	always_ff @(posedge clk) begin
		if (map_req.wr_en) begin
			mem[map_req.wr_addr] <= map_req.wr_data;
		end
		if (map_req.rd_en) begin
			mem_rd_s1 <= mem[map_req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (map_req.wr_en) begin
				row_valid_q[map_req.wr_addr] <= 1'b1;
			end
			if (map_req.rd_en) begin
				rd_valid_s1 <= row_valid_q[map_req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? mem_rd_s1 : '0;

endmodule

>>> sv/bitmap_block_allocator_core.sv
// Bitmap block allocator: one allocation bit per block, all blocks free after reset.
// The req channel carries one operation per item (set, clear, check, find first
// free and set, find first used and clear); the rsp channel returns exactly one
// item per request with a hit flag and the index found by a find.
// Both channels use valid/ready; the configuration port is APB-style and holds
// block_count at address 0, which is to be written only while the block is idle;
// the block itself does not enforce this. The map lives in a 32-word synchronous
// memory read one word per cycle. Set, clear and check do one memory read, then
// set and clear write the modified word back and check compares the bit.
// A find scans one word per cycle with a priority encoder per word, and stops at
// the first word holding a candidate or at the last word below block_count.
// The response sits in an output register, so a new request is taken while an
// earlier response waits; if that response is still stalled when the next one
// is ready, the block holds its work and writes nothing until rsp_ready.
// Reset clears the map at once through per-word valid bits and sets
// block_count to 1024; no clearing pass is needed.
`include "assert_macros.svh"

module bitmap_block_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bba_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bba_pkg::rsp_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bba_pkg::PADDR_W-1:0]   paddr,
	input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
	output logic [bba_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_OP   = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	localparam int NB_W = bba_pkg::WORD_W + 1 + bba_pkg::BIT_W;

	logic [1:0]                          state_q, state_d;
	bba_pkg::req_t                       op_q;
	logic [bba_pkg::WORD_W-1:0]          word_q, word_d;
	logic [bba_pkg::CNT_W-1:0]           count_q;
	logic [bba_pkg::CNT_W-1:0]           eff_count;
	bba_pkg::rsp_t                       rsp_q, rsp_d;
	logic                                rsp_valid_q;
	logic                                res_load;
	logic                                accept;
	logic                                out_free;
	logic                                req_is_find;
	bba_pkg::map_req_t                   map_req;
	logic [bba_pkg::WORD_BITS-1:0]       rd_word;
	logic [bba_pkg::WORD_BITS-1:0]       bit_sel;
	logic                                cur_bit;
	logic                                in_range;
	logic [bba_pkg::WORD_BITS-1:0]       cand;
	logic                                found;
	logic [bba_pkg::BIT_W-1:0]           found_off;
	logic [bba_pkg::WORD_BITS-1:0]       found_sel;
	logic [NB_W-1:0]                     next_base;
	logic                                scan_last;
	logic                                cfg_wr;

	bba_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.map_req (map_req),
		.rd_data (rd_word)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[bba_pkg::PADDR_W-1:2] == bba_pkg::REG_BLOCK_COUNT);
	assign prdata = (paddr[bba_pkg::PADDR_W-1:2] == bba_pkg::REG_BLOCK_COUNT)
		? bba_pkg::PDATA_W'(count_q) : '0;

	assign eff_count = (count_q > bba_pkg::BLOCK_COUNT_MAX) ? bba_pkg::BLOCK_COUNT_MAX : count_q;

	assign req_ready   = (state_q == ST_IDLE);
	assign accept      = req_valid && req_ready;
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign req_is_find = (req.func == bba_pkg::FUNC_FIND_SET)
		|| (req.func == bba_pkg::FUNC_FIND_CLR);

	assign bit_sel  = bba_pkg::WORD_BITS'(1) << (bba_pkg::BIT_W'(bba_pkg::WORD_BITS - 1)
		- op_q.block_index[bba_pkg::BIT_W-1:0]);
	assign cur_bit  = |(rd_word & bit_sel);
	assign in_range = {1'b0, op_q.block_index} < eff_count;

	always_comb begin
		cand      = '0;
		found     = 1'b0;
		found_off = '0;
		for (int p = 0; p < bba_pkg::WORD_BITS; p++) begin
			if ({1'b0, word_q, bba_pkg::BIT_W'(p)} < eff_count) begin
				cand[bba_pkg::WORD_BITS-1-p] = (op_q.func == bba_pkg::FUNC_FIND_SET)
					? !rd_word[bba_pkg::WORD_BITS-1-p] : rd_word[bba_pkg::WORD_BITS-1-p];
			end
		end
		for (int p = bba_pkg::WORD_BITS - 1; p >= 0; p--) begin
			if (cand[bba_pkg::WORD_BITS-1-p]) begin
				found     = 1'b1;
				found_off = bba_pkg::BIT_W'(p);
			end
		end
	end

	assign found_sel = bba_pkg::WORD_BITS'(1)
		<< (bba_pkg::BIT_W'(bba_pkg::WORD_BITS - 1) - found_off);
	assign next_base = NB_W'({1'b0, word_q} + 1'b1) << bba_pkg::BIT_W;
	assign scan_last = (word_q == bba_pkg::WORD_W'(bba_pkg::MAP_WORDS - 1))
		|| (next_base >= NB_W'(eff_count));

	always_comb begin
		state_d         = state_q;
		word_d          = word_q;
		res_load        = 1'b0;
		rsp_d           = '0;
		map_req         = '0;
		map_req.wr_addr = word_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = req_is_find ? '0
						: req.block_index[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
					word_d          = req_is_find ? '0
						: req.block_index[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
					state_d         = req_is_find ? ST_SCAN : ST_OP;
				end
			end
			ST_OP: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
					case (op_q.func)
						bba_pkg::FUNC_SET: begin
							map_req.wr_en   = in_range;
							map_req.wr_data = rd_word | bit_sel;
						end
						bba_pkg::FUNC_CLEAR: begin
							map_req.wr_en   = in_range;
							map_req.wr_data = rd_word & ~bit_sel;
						end
						bba_pkg::FUNC_CHECK: begin
							rsp_d.hit = in_range && (cur_bit == op_q.expect_set);
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (found) begin
					if (out_free) begin
						map_req.wr_en   = 1'b1;
						map_req.wr_data = rd_word ^ found_sel;
						res_load        = 1'b1;
						rsp_d.hit       = 1'b1;
						rsp_d.index     = {word_q, found_off};
						state_d         = ST_IDLE;
					end
				end else if (scan_last) begin
					if (out_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = word_q + 1'b1;
					word_d          = word_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req;
		end
		if (res_load) begin
			rsp_q <= rsp_d;
		end
		word_q <= word_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= bba_pkg::BLOCK_COUNT_RESET;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				count_q <= pwdata[bba_pkg::CNT_W-1:0];
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BBA_ASSERT_NOW(a_no_rsp_overwrite, res_load, !rsp_valid_q || rsp_ready, "Pending response overwritten.")
	`BBA_ASSERT_NOW(a_write_only_when_busy, map_req.wr_en, res_load, "Map written without a response.")
	`BBA_ASSERT_NOW(a_index_only_on_hit, rsp_valid_q, rsp_q.hit || (rsp_q.index == '0), "Index set on a miss.")
	`BBA_ASSERT_NEXT(a_find_hit_in_range, res_load && rsp_d.hit && (state_q == ST_SCAN), {1'b0, rsp_q.index} < eff_count, "Find returned a block beyond the count.")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import bba_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_BLOCK_COUNT + 1'b1;
	localparam logic [PADDR_W-1:0] ADDR_BLOCK_COUNT = {REG_BLOCK_COUNT, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_SPARE = {REG_SPARE, 2'b00};

	class alloc_scoreboard;
		bit [MAX_BLOCKS-1:0] used;
		logic [CNT_W-1:0] count;
		rsp_t due[$];
		int errors;

		function new();
			used = '0;
			count = BLOCK_COUNT_RESET;
			errors = 0;
		endfunction

		function void write_count(logic [PDATA_W-1:0] value);
			count = value[CNT_W-1:0];
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void note_request(req_t r);
			int unsigned lim;
			int unsigned blk;
			rsp_t e;
			lim = (count > BLOCK_COUNT_MAX) ? MAX_BLOCKS : count;
			blk = r.block_index;
			e = '0;
			case (r.func)
				FUNC_SET: begin
					if (blk < lim)
						used[blk] = 1'b1;
				end
				FUNC_CLEAR: begin
					if (blk < lim)
						used[blk] = 1'b0;
				end
				FUNC_CHECK: begin
					if (blk < lim && used[blk] == r.expect_set)
						e.hit = 1'b1;
				end
				FUNC_FIND_SET, FUNC_FIND_CLR: begin
					for (int i = 0; i < lim; i++) begin
						if (used[i] == (r.func == FUNC_FIND_CLR)) begin
							used[i] = (r.func == FUNC_FIND_SET);
							e.hit = 1'b1;
							e.index = IDX_W'(i);
							break;
						end
					end
				end
				default: begin
				end
			endcase
			due.push_back(e);
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, got hit=%0d index=%0d",
					$time, a.hit, a.index);
				return;
			end
			e = due.pop_front();
			if (a.hit !== e.hit || a.index !== e.index) begin
				errors++;
				$display("%0t: expected hit=%0d index=%0d, got hit=%0d index=%0d",
					$time, e.hit, e.index, a.hit, a.index);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	bit quiet = 1'b0;
	alloc_scoreboard sb;

	bitmap_block_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= quiet || ($urandom_range(99) >= 21);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
		end
	end

	task automatic send_item(input req_t r);
		while (!quiet && $urandom_range(99) < 21) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic send_op(input logic [FUNC_W-1:0] func, input int unsigned blk,
			input bit exp_bit);
		req_t r;
		r.func = func;
		r.block_index = IDX_W'(blk);
		r.expect_set = exp_bit;
		send_item(r);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_BLOCK_COUNT)
			sb.write_count(data);
	endtask

	function automatic req_t random_request(int unsigned lo, int unsigned hi,
			int unsigned fs_pct, int unsigned fc_pct);
		req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 3) begin
			r.func = FUNC_UNUSED_LO + FUNC_W'($urandom_range(2));
		end else if (pick < 3 + fs_pct) begin
			r.func = FUNC_FIND_SET;
		end else if (pick < 3 + fs_pct + fc_pct) begin
			r.func = FUNC_FIND_CLR;
		end else begin
			case ($urandom_range(2))
				0: r.func = FUNC_SET;
				1: r.func = FUNC_CLEAR;
				default: r.func = FUNC_CHECK;
			endcase
		end
		if ($urandom_range(9) == 0)
			r.block_index = IDX_W'($urandom);
		else
			r.block_index = IDX_W'($urandom_range(hi, lo));
		r.expect_set = 1'($urandom_range(1));
		return r;
	endfunction

	task automatic random_phase(input int n, input int unsigned lo, input int unsigned hi,
			input int unsigned fs_pct, input int unsigned fc_pct);
		repeat (n) send_item(random_request(lo, hi, fs_pct, fc_pct));
	endtask

	initial begin
		#20_000_000;
		$display("bitmap_block_allocator_core: mismatch");
		$finish;
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(FUNC_CHECK, 0, 1'b0);
		send_op(FUNC_CHECK, 1023, 1'b1);
		send_op(FUNC_SET, 0, 1'b0);
		send_op(FUNC_SET, 1023, 1'b1);
		send_op(FUNC_CHECK, 1023, 1'b1);
		send_op(FUNC_CHECK, 0, 1'b0);
		send_op(FUNC_FIND_SET, 1023, 1'b1);
		send_op(FUNC_FIND_CLR, 0, 1'b0);
		send_op(FUNC_CLEAR, 1023, 1'b0);
		send_op(FUNC_UNUSED_LO, 1023, 1'b1);
		send_op(FUNC_UNUSED_LO + 3'd1, 0, 1'b0);
		send_op(FUNC_UNUSED_LO + 3'd2, 682, 1'b1);
		send_op(FUNC_FIND_CLR, 341, 1'b0);
		send_op(FUNC_FIND_CLR, 0, 1'b1);

		// With a zero count every index is out of range and finds miss.
		write_reg(ADDR_BLOCK_COUNT, 32'd0);
		send_op(FUNC_SET, 0, 1'b1);
		send_op(FUNC_CHECK, 0, 1'b0);
		send_op(FUNC_FIND_SET, 0, 1'b0);

		write_reg(ADDR_BLOCK_COUNT, 32'd1);
		send_op(FUNC_FIND_SET, 0, 1'b0);
		send_op(FUNC_FIND_SET, 0, 1'b0);
		send_op(FUNC_CHECK, 1, 1'b0);
		send_op(FUNC_FIND_CLR, 0, 1'b0);

		// A count above the map size saturates.
		write_reg(ADDR_BLOCK_COUNT, 32'hFFFF_FFFF);
		send_op(FUNC_SET, 1023, 1'b0);
		send_op(FUNC_CHECK, 1023, 1'b1);

		write_reg(ADDR_SPARE, 32'd5);
		send_op(FUNC_CHECK, 1023, 1'b1);
		send_op(FUNC_CLEAR, 1023, 1'b0);

		// High blocks only, so finds of a used block scan nearly the whole map.
		write_reg(ADDR_BLOCK_COUNT, 32'(BLOCK_COUNT_MAX));
		random_phase(120, 960, 1023, 5, 20);

		quiet = 1'b1;
		random_phase(120, 0, 1023, 55, 5);
		quiet = 1'b0;

		write_reg(ADDR_BLOCK_COUNT, 32'd33);
		random_phase(100, 0, 40, 25, 25);

		write_reg(ADDR_BLOCK_COUNT, 32'($urandom_range(1024, 1)));
		random_phase(100, 0, 1023, 30, 15);

		write_reg(ADDR_BLOCK_COUNT, 32'd2047);
		random_phase(110, 0, 200, 35, 35);

		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("bitmap_block_allocator_core: match");
		else
			$display("bitmap_block_allocator_core: mismatch");
		$finish;
	end
endmodule
